@@ rtl/mm3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg: shared widths and constants for the chained 128-bit hash
// Widths of the request and response fields and the mixing constants.
// ----------------------------------------------------------------------------
package mm3_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int VB_W   = 5;

   localparam logic [VB_W-1:0] BLOCK_BYTES = VB_W'(16);

   localparam logic [WORD_W-1:0] MIX_C1  = 64'h87c3_7b91_1142_53d5;
   localparam logic [WORD_W-1:0] MIX_C2  = 64'h4cf5_ad43_2745_937f;
   localparam logic [WORD_W-1:0] FIN_M1  = 64'hff51_afd7_ed55_8ccd;
   localparam logic [WORD_W-1:0] FIN_M2  = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [WORD_W-1:0] ADD_ONE = 64'h0000_0000_52dc_e729;
   localparam logic [WORD_W-1:0] ADD_TWO = 64'h0000_0000_3849_5ab5;

endpackage : mm3_pkg
`default_nettype wire

@@ rtl/mm3_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_if: request and response channels
// Valid/ready channels carrying one message block in and one hash out.
// ----------------------------------------------------------------------------
interface mm3_req_if import mm3_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_low;
   logic [WORD_W-1:0] word_high;
   logic [VB_W-1:0]   valid_bytes;
   logic              last_block;

   modport source (output valid, word_low, word_high, valid_bytes, last_block,
                   input ready);
   modport sink   (input valid, word_low, word_high, valid_bytes, last_block,
                   output ready);
endinterface : mm3_req_if

interface mm3_rsp_if import mm3_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_low;
   logic [WORD_W-1:0] hash_high;

   modport source (output valid, hash_low, hash_high, input ready);
   modport sink   (input valid, hash_low, hash_high, output ready);
endinterface : mm3_rsp_if
`default_nettype wire

@@ rtl/mm3_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_mul: shared 64x64 multiplier, low half of the product
// One 32x32 multiplier walks three partial products; done flags the product
// once the last partial product is accumulated, while run is held.
// ----------------------------------------------------------------------------
module mm3_mul import mm3_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              run,
   input  wire logic [WORD_W-1:0] op_a,
   input  wire logic [WORD_W-1:0] op_b,
   output logic                   done,
   output logic [WORD_W-1:0]      product
);

   localparam logic [1:0] STEP_LL   = 2'd0;
   localparam logic [1:0] STEP_LH   = 2'd1;
   localparam logic [1:0] STEP_HL   = 2'd2;
   localparam logic [1:0] STEP_DONE = 2'd3;

   logic [1:0]        step_ff, step_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0] mul_x, mul_y;
   logic [WORD_W-1:0] part;

   // pick the halves for this step
   assign mul_x = (step_ff == STEP_HL) ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
   assign mul_y = (step_ff == STEP_LH) ? op_b[WORD_W-1:HALF_W] : op_b[HALF_W-1:0];
   assign part  = WORD_W'(mul_x) * WORD_W'(mul_y);

   assign done    = run && (step_ff == STEP_DONE);
   assign product = acc_ff;

   always_comb begin
      step_in = STEP_LL;
      acc_in  = acc_ff;
      if (run) begin
         step_in = (step_ff == STEP_DONE) ? STEP_LL : step_ff + 2'd1;
         case (step_ff)
            STEP_LL: begin
               acc_in = part;
            end
            STEP_LH, STEP_HL: begin
               // cross terms land in the upper half only
               acc_in = {acc_ff[WORD_W-1:HALF_W] + part[HALF_W-1:0],
                         acc_ff[HALF_W-1:0]};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LL;
      end else begin
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
   end

endmodule : mm3_mul
`default_nettype wire

@@ rtl/murmur3_x64_128_chained_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur3_x64_128_chained_hash: chained 128-bit block hash, one shared multiplier
// Flow: ready is high only in idle, so a non-final block holds ready low until
//   its body mixing is done; a short final block skips the body mixing.
// Requests are taken one at a time, not before the last one is through; each
//   64-bit multiply runs on the shared multiplier, eight multiplies per final block.
// Reset: synchronous, active high; clears both lanes, the byte count and the
//   response slot, so the first message is seeded with zero.
// ----------------------------------------------------------------------------
module murmur3_x64_128_chained_hash import mm3_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mm3_req_if.sink   req_chan,
   mm3_rsp_if.source rsp_chan
);

   typedef enum logic [21:0] {
      S_IDLE  = 22'b0000000000000000000001,
      S_K1A   = 22'b0000000000000000000010,
      S_K1B   = 22'b0000000000000000000100,
      S_K2A   = 22'b0000000000000000001000,
      S_K2B   = 22'b0000000000000000010000,
      S_MIXA  = 22'b0000000000000000100000,
      S_MIXB  = 22'b0000000000000001000000,
      S_MIXC  = 22'b0000000000000010000000,
      S_MIXD  = 22'b0000000000000100000000,
      S_SHORT = 22'b0000000000001000000000,
      S_FXOR  = 22'b0000000000010000000000,
      S_FADD1 = 22'b0000000000100000000000,
      S_FADD2 = 22'b0000000001000000000000,
      S_F1X   = 22'b0000000010000000000000,
      S_F1A   = 22'b0000000100000000000000,
      S_F1B   = 22'b0000001000000000000000,
      S_F2X   = 22'b0000010000000000000000,
      S_F2A   = 22'b0000100000000000000000,
      S_F2B   = 22'b0001000000000000000000,
      S_FSUM1 = 22'b0010000000000000000000,
      S_FSUM2 = 22'b0100000000000000000000,
      S_OUT   = 22'b1000000000000000000000
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [WORD_W-1:0] lane1_ff, lane1_in;
   logic [WORD_W-1:0] lane2_ff, lane2_in;
   logic [WORD_W-1:0] total_ff, total_in;

   // per-block working registers
   logic [WORD_W-1:0] lo_ff, lo_in;
   logic [WORD_W-1:0] hi_ff, hi_in;
   logic [WORD_W-1:0] work_ff, work_in;
   logic [WORD_W-1:0] k1_ff, k1_in;
   logic [WORD_W-1:0] k2_ff, k2_in;
   logic              last_ff, last_in;
   logic              body_ff, body_in;

   // response slot
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_low_ff, rsp_low_in;
   logic [WORD_W-1:0] rsp_high_ff, rsp_high_in;

   // shared multiplier
   logic              mul_run;
   logic [WORD_W-1:0] mul_a, mul_b;
   logic              mul_done;
   logic [WORD_W-1:0] mul_p;

   // request decode
   logic [VB_W-1:0]   vb_sat;
   logic              req_body;
   logic [7:0]        keep_lo, keep_hi;
   logic [WORD_W-1:0] mask_lo, mask_hi;
   logic [VB_W-1:0]   byte_add;
   logic [WORD_W-1:0] tmp1, tmp2;

   mm3_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .run     (mul_run),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hash_low  = rsp_low_ff;
   assign rsp_chan.hash_high = rsp_high_ff;

   // Clamp the byte count, then build byte masks. A block that is not last,
   // or a full last block, keeps every byte and gets the body mixing.
   always_comb begin
      vb_sat   = (req_chan.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : req_chan.valid_bytes;
      req_body = !req_chan.last_block || (vb_sat == BLOCK_BYTES);
      byte_add = req_body ? BLOCK_BYTES : vb_sat;
      for (int i = 0; i < 8; i++) begin
         keep_lo[i] = req_body || (vb_sat > VB_W'(i));
         keep_hi[i] = req_body || (vb_sat > VB_W'(i + 8));
         mask_lo[8*i +: 8] = {8{keep_lo[i]}};
         mask_hi[8*i +: 8] = {8{keep_hi[i]}};
      end
   end

   // Sequencer. Masked-off bytes make the key mix yield zero, so a short
   // last block runs the same key mixes and only XORs the results in.
   always_comb begin
      state_in     = state_ff;
      lane1_in     = lane1_ff;
      lane2_in     = lane2_ff;
      total_in     = total_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      work_in      = work_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      last_in      = last_ff;
      body_in      = body_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      mul_run      = 1'b0;
      mul_a        = lo_ff;
      mul_b        = MIX_C1;
      tmp1         = '0;
      tmp2         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               lo_in    = req_chan.word_low & mask_lo;
               hi_in    = req_chan.word_high & mask_hi;
               last_in  = req_chan.last_block;
               body_in  = req_body;
               total_in = total_ff + WORD_W'(byte_add);
               state_in = S_K1A;
            end
         end
         // key one: multiply, rotate by 31, multiply
         S_K1A: begin
            mul_run = 1'b1;
            mul_a   = lo_ff;
            mul_b   = MIX_C1;
            if (mul_done) begin
               work_in  = {mul_p[32:0], mul_p[63:33]};
               state_in = S_K1B;
            end
         end
         S_K1B: begin
            mul_run = 1'b1;
            mul_a   = work_ff;
            mul_b   = MIX_C2;
            if (mul_done) begin
               k1_in    = mul_p;
               state_in = S_K2A;
            end
         end
         // key two: multiply, rotate by 33, multiply
         S_K2A: begin
            mul_run = 1'b1;
            mul_a   = hi_ff;
            mul_b   = MIX_C2;
            if (mul_done) begin
               work_in  = {mul_p[30:0], mul_p[63:31]};
               state_in = S_K2B;
            end
         end
         S_K2B: begin
            mul_run = 1'b1;
            mul_a   = work_ff;
            mul_b   = MIX_C1;
            if (mul_done) begin
               k2_in    = mul_p;
               state_in = body_ff ? S_MIXA : S_SHORT;
            end
         end
         // body mixing of lane one, then lane two
         S_MIXA: begin
            tmp1     = lane1_ff ^ k1_ff;
            lane1_in = {tmp1[36:0], tmp1[63:37]} + lane2_ff;
            state_in = S_MIXB;
         end
         S_MIXB: begin
            lane1_in = lane1_ff + {lane1_ff[61:0], 2'b00} + ADD_ONE;
            state_in = S_MIXC;
         end
         S_MIXC: begin
            tmp2     = lane2_ff ^ k2_ff;
            lane2_in = {tmp2[32:0], tmp2[63:33]} + lane1_ff;
            state_in = S_MIXD;
         end
         S_MIXD: begin
            lane2_in = lane2_ff + {lane2_ff[61:0], 2'b00} + ADD_TWO;
            state_in = last_ff ? S_FXOR : S_IDLE;
         end
         S_SHORT: begin
            lane1_in = lane1_ff ^ k1_ff;
            lane2_in = lane2_ff ^ k2_ff;
            state_in = S_FXOR;
         end
         // finalization: fold in length, cross add
         S_FXOR: begin
            lane1_in = lane1_ff ^ total_ff;
            lane2_in = lane2_ff ^ total_ff;
            state_in = S_FADD1;
         end
         S_FADD1: begin
            lane1_in = lane1_ff + lane2_ff;
            total_in = '0;
            state_in = S_FADD2;
         end
         S_FADD2: begin
            lane2_in = lane2_ff + lane1_ff;
            state_in = S_F1X;
         end
         // fmix on lane one
         S_F1X: begin
            lane1_in = lane1_ff ^ {33'b0, lane1_ff[63:33]};
            state_in = S_F1A;
         end
         S_F1A: begin
            mul_run = 1'b1;
            mul_a   = lane1_ff;
            mul_b   = FIN_M1;
            if (mul_done) begin
               lane1_in = mul_p ^ {33'b0, mul_p[63:33]};
               state_in = S_F1B;
            end
         end
         S_F1B: begin
            mul_run = 1'b1;
            mul_a   = lane1_ff;
            mul_b   = FIN_M2;
            if (mul_done) begin
               lane1_in = mul_p ^ {33'b0, mul_p[63:33]};
               state_in = S_F2X;
            end
         end
         // fmix on lane two
         S_F2X: begin
            lane2_in = lane2_ff ^ {33'b0, lane2_ff[63:33]};
            state_in = S_F2A;
         end
         S_F2A: begin
            mul_run = 1'b1;
            mul_a   = lane2_ff;
            mul_b   = FIN_M1;
            if (mul_done) begin
               lane2_in = mul_p ^ {33'b0, mul_p[63:33]};
               state_in = S_F2B;
            end
         end
         S_F2B: begin
            mul_run = 1'b1;
            mul_a   = lane2_ff;
            mul_b   = FIN_M2;
            if (mul_done) begin
               lane2_in = mul_p ^ {33'b0, mul_p[63:33]};
               state_in = S_FSUM1;
            end
         end
         S_FSUM1: begin
            lane1_in = lane1_ff + lane2_ff;
            state_in = S_FSUM2;
         end
         S_FSUM2: begin
            lane2_in = lane2_ff + lane1_ff;
            state_in = S_OUT;
         end
         // hold until the response slot is free, then load it
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_low_in   = lane1_ff;
               rsp_high_in  = lane2_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lane1_ff     <= '0;
         lane2_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane1_ff     <= lane1_in;
         lane2_ff     <= lane2_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      work_ff     <= work_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      last_ff     <= last_in;
      body_ff     <= body_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
   end

endmodule : murmur3_x64_128_chained_hash
`default_nettype wire
